FILE: src/crcdf_pkg.sv
package crcdf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned TdataW  = 64;

  localparam logic [CrcW-1:0]  CrcPoly         = 16'hA001;
  localparam logic [CrcW-1:0]  CrcInit         = 16'hFFFF;
  localparam logic [ByteW-1:0] StartByteReset  = 8'hAA;
  localparam logic [LenW-1:0]  MaxPayloadReset = 16'd1024;

  // Register indexes on the configuration port.
  localparam logic [AddrW-3:0] RegStartByte  = 1'b0;
  localparam logic [AddrW-3:0] RegMaxPayload = 1'b1;

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_CMD     = 8'b0000_0010,
    PH_SEQ     = 8'b0000_0100,
    PH_LEN_LO  = 8'b0000_1000,
    PH_LEN_HI  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_LO  = 8'b0100_0000,
    PH_CRC_HI  = 8'b1000_0000
  } phase_t;

  typedef enum logic [StatusW-1:0] {
    ST_NONE    = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  // One byte of reflected CRC-16, eight bit steps unrolled into XOR logic.
  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc_in,
                                                 input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/crc16_checked_frame_deframer_unit.sv
// Frame deframer with CRC-16/MODBUS check.
//
// Input stream: one received byte per beat on s_tdata. Each accepted byte
// yields exactly one result beat on the master side. The frame is a start
// byte, command, sequence, 16-bit little-endian length, payload and a
// little-endian CRC; the CRC covers everything after the start byte.
// Payload bytes come out as they arrive, flagged by m_tuser, with their index.
// frame_status reports a good frame or a CRC mismatch on the last CRC byte,
// and a length above max_payload on the second length byte.
//
// The byte lands in an input register; the parser state and the one-byte
// CRC update sit between it and the result register.
// Throughput is one byte per cycle while the receiver takes beats.
// When m_tready is low the result register holds its beat, the input register
// takes one more byte only if it is empty, and then s_tready falls.
// Synchronous reset returns the parser to hunting for the start byte and
// restores the registers to start byte 0xAA and max payload 1024.
// Registers: start_byte at address 0, max_payload at address 4. Write them
// only while no beat is in flight.
module crc16_checked_frame_deframer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [crcdf_pkg::ByteW-1:0]   s_tdata,  // [7:0] rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_cmd,
  // [39:32] frame_seq, [55:40] declared_len, [57:56] frame_status, rest zero
  output logic [crcdf_pkg::TdataW-1:0]  m_tdata,
  output logic                          m_tuser,  // [0] payload_valid
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crcdf_pkg::AddrW-1:0]   paddr,
  input  logic [crcdf_pkg::DataW-1:0]   pwdata,
  output logic [crcdf_pkg::DataW-1:0]   prdata,
  output logic                          pready
);
  import crcdf_pkg::*;

  logic [ByteW-1:0] start_byte;
  logic [LenW-1:0]  max_payload;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             advance;

  phase_t           phase, phase_next;
  logic [CrcW-1:0]  crc, crc_next;
  logic [ByteW-1:0] cmd, cmd_next;
  logic [ByteW-1:0] seq, seq_next;
  logic [LenW-1:0]  len, len_next;
  logic [LenW-1:0]  count, count_next;
  logic [ByteW-1:0] crc_low, crc_low_next;

  logic [ByteW-1:0] pay_byte;
  logic             pay_valid;
  logic [LenW-1:0]  pay_index;
  status_t          status;
  logic [CrcW-1:0]  crc_upd;

  logic [ByteW-1:0] out_byte;
  logic [LenW-1:0]  out_index;
  logic [ByteW-1:0] out_cmd;
  logic [ByteW-1:0] out_seq;
  logic [LenW-1:0]  out_len;
  status_t          out_status;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte  <= StartByteReset;
      max_payload <= MaxPayloadReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[AddrW-1:2])
        RegStartByte:  start_byte  <= pwdata[ByteW-1:0];
        RegMaxPayload: max_payload <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[AddrW-1:2])
      RegStartByte:  prdata = {{(DataW-ByteW){1'b0}}, start_byte};
      RegMaxPayload: prdata = {{(DataW-LenW){1'b0}}, max_payload};
      default:       prdata = '0;
    endcase
  end

  // Input register; the parser consumes it whenever the result register is free.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  assign crc_upd = crc16_byte(crc, in_byte);

  always_comb begin
    phase_next   = phase;
    crc_next     = crc;
    cmd_next     = cmd;
    seq_next     = seq;
    len_next     = len;
    count_next   = count;
    crc_low_next = crc_low;
    pay_byte     = '0;
    pay_valid    = 1'b0;
    pay_index    = '0;
    status       = ST_NONE;
    case (phase)
      PH_HUNT: begin
        if (in_byte == start_byte) begin
          phase_next = PH_CMD;
          crc_next   = CrcInit;
        end
      end
      PH_CMD: begin
        cmd_next   = in_byte;
        crc_next   = crc_upd;
        phase_next = PH_SEQ;
      end
      PH_SEQ: begin
        seq_next   = in_byte;
        crc_next   = crc_upd;
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_next   = {{(LenW-ByteW){1'b0}}, in_byte};
        crc_next   = crc_upd;
        phase_next = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_next = {in_byte, len[ByteW-1:0]};
        crc_next = crc_upd;
        if (len_next > max_payload) begin
          status     = ST_TOO_LONG;
          phase_next = PH_HUNT;
        end else if (len_next == '0) begin
          phase_next = PH_CRC_LO;
        end else begin
          count_next = '0;
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pay_byte   = in_byte;
        pay_valid  = 1'b1;
        pay_index  = count;
        crc_next   = crc_upd;
        count_next = count + 1'b1;
        if (count_next >= len) begin
          phase_next = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_low_next = in_byte;
        phase_next   = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        phase_next = PH_HUNT;
        status     = ({in_byte, crc_low} == crc) ? ST_GOOD : ST_BAD_CRC;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      crc     <= CrcInit;
      cmd     <= '0;
      seq     <= '0;
      len     <= '0;
      count   <= '0;
      crc_low <= '0;
    end else if (advance) begin
      phase   <= phase_next;
      crc     <= crc_next;
      cmd     <= cmd_next;
      seq     <= seq_next;
      len     <= len_next;
      count   <= count_next;
      crc_low <= crc_low_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= pay_byte;
      m_tuser    <= pay_valid;
      out_index  <= pay_index;
      out_cmd    <= cmd_next;
      out_seq    <= seq_next;
      out_len    <= len_next;
      out_status <= status;
    end
  end

  assign m_tdata = {{(TdataW - 2*ByteW - 2*LenW - ByteW - StatusW){1'b0}},
                    out_status, out_len, out_seq, out_cmd, out_index, out_byte};

  // A payload beat never carries a frame status.
  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> out_status == ST_NONE)
    else $error("payload beat carries a frame status");

  // A payload index always lies inside the declared length.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> out_index < out_len)
    else $error("payload index beyond declared length");

  // The last CRC byte always ends in a good or mismatch status.
  a_crc_hi_status: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_CRC_HI |=>
      m_tvalid && (out_status == ST_GOOD || out_status == ST_BAD_CRC))
    else $error("last CRC byte without a check status");

  // A held input byte is not overwritten while the result register is stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input register overrun during stall");

endmodule

FILE: test/crc16_checked_frame_deframer_unit_tb.sv
`timescale 1ns / 1ps

module crc16_checked_frame_deframer_unit_tb;
  import crcdf_pkg::*;

  localparam int HoldCycles   = 400;
  localparam int StallLimit   = 3000;
  localparam int SegmentItems = 280;

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_TOO_LONG, FR_CUT} frame_kind_t;

  class deframer_scoreboard;
    typedef struct packed {
      logic [ByteW-1:0] pay_byte;
      logic             pay_valid;
      logic [LenW-1:0]  pay_index;
      logic [ByteW-1:0] cmd;
      logic [ByteW-1:0] seq;
      logic [LenW-1:0]  len;
      status_t          status;
    } beat_t;

    logic [ByteW-1:0] start_val;
    logic [LenW-1:0]  max_len;
    phase_t           phase;
    logic [CrcW-1:0]  crc;
    logic [ByteW-1:0] cmd;
    logic [ByteW-1:0] seq;
    logic [LenW-1:0]  len;
    logic [LenW-1:0]  count;
    logic [ByteW-1:0] crc_lo;
    beat_t            expected[$];
    int errors;
    int checked;
    int n_good;
    int n_bad;
    int n_drop;
    int n_payload;

    function new();
      start_val = StartByteReset;
      max_len   = MaxPayloadReset;
      phase     = PH_HUNT;
      crc       = CrcInit;
      cmd       = '0;
      seq       = '0;
      len       = '0;
      count     = '0;
      crc_lo    = '0;
    endfunction

    // Bit-serial form of the reflected CRC: feed data LSB first.
    function logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] c_in,
                                       input logic [ByteW-1:0] d);
      logic [CrcW-1:0] c;
      logic fb;
      c = c_in;
      for (int i = 0; i < ByteW; i++) begin
        fb = c[0] ^ d[i];
        c = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    function void note_byte(input logic [ByteW-1:0] b);
      beat_t e;
      e = '0;
      e.status = ST_NONE;
      case (phase)
        PH_HUNT: begin
          if (b == start_val) begin
            phase = PH_CMD;
            crc = CrcInit;
          end
        end
        PH_CMD: begin
          cmd = b;
          crc = crc_fold(crc, b);
          phase = PH_SEQ;
        end
        PH_SEQ: begin
          seq = b;
          crc = crc_fold(crc, b);
          phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len = {8'h00, b};
          crc = crc_fold(crc, b);
          phase = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len = {b, len[7:0]};
          crc = crc_fold(crc, b);
          if (len > max_len) begin
            e.status = ST_TOO_LONG;
            phase = PH_HUNT;
          end else if (len == 0) begin
            phase = PH_CRC_LO;
          end else begin
            count = '0;
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          e.pay_byte = b;
          e.pay_valid = 1'b1;
          e.pay_index = count;
          crc = crc_fold(crc, b);
          count = count + 1'b1;
          if (count >= len) phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_lo = b;
          phase = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          phase = PH_HUNT;
          e.status = ({b, crc_lo} == crc) ? ST_GOOD : ST_BAD_CRC;
        end
        default: begin
          phase = PH_HUNT;
        end
      endcase
      e.cmd = cmd;
      e.seq = seq;
      e.len = len;
      expected.push_back(e);
    endfunction

    task report_mismatch(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("beat %0d: %s is %0h, expected %0h", checked, what, got, want);
      errors++;
    endtask

    task check_result(input logic [TdataW-1:0] data, input logic user);
      beat_t e;
      if (expected.size() == 0) begin
        report_mismatch("beat with nothing pending", data, '0);
        return;
      end
      e = expected.pop_front();
      checked++;
      if (user !== e.pay_valid) report_mismatch("payload_valid", user, e.pay_valid);
      if (data[7:0] !== e.pay_byte) report_mismatch("payload_byte", data[7:0], e.pay_byte);
      if (data[23:8] !== e.pay_index) report_mismatch("payload_index", data[23:8], e.pay_index);
      if (data[31:24] !== e.cmd) report_mismatch("frame_cmd", data[31:24], e.cmd);
      if (data[39:32] !== e.seq) report_mismatch("frame_seq", data[39:32], e.seq);
      if (data[55:40] !== e.len) report_mismatch("declared_len", data[55:40], e.len);
      if (data[57:56] !== e.status) report_mismatch("frame_status", data[57:56], e.status);
      if (e.pay_valid) n_payload++;
      case (e.status)
        ST_GOOD:     n_good++;
        ST_BAD_CRC:  n_bad++;
        ST_TOO_LONG: n_drop++;
        default: ;
      endcase
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TdataW-1:0]   m_tdata;
  logic                m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  deframer_scoreboard sb = new();

  int send_idle_pct = 29;
  int recv_idle_pct = 67;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  crc16_checked_frame_deframer_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side: checks each beat and drives the back-pressure pattern.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else if (!rst) begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no beat moved for %0d cycles", stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input bit counts);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
    if (counts) items_sent++;
  endtask

  // Sends start byte, body and CRC (xored with flip); keep > 0 truncates.
  task automatic send_built(input logic [ByteW-1:0] body[$], input logic [CrcW-1:0] flip,
                            input int keep);
    logic [ByteW-1:0] wire_q[$];
    logic [CrcW-1:0]  c;
    int n;
    c = CrcInit;
    foreach (body[i]) c = sb.crc_fold(c, body[i]);
    c = c ^ flip;
    wire_q = body;
    wire_q.push_front(sb.start_val);
    wire_q.push_back(c[7:0]);
    wire_q.push_back(c[15:8]);
    n = (keep > 0) ? keep : wire_q.size();
    for (int i = 0; i < n; i++) send_byte(wire_q[i], 1'b1);
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [ByteW-1:0] body[$];
    logic [LenW-1:0]  len_v;
    logic [CrcW-1:0]  flip;
    int mx;
    int len_i;
    int keep;
    mx = sb.max_len;
    if (kind == FR_TOO_LONG && mx == 65535) kind = FR_GOOD;
    if (kind == FR_CUT && mx > 2000) kind = FR_BAD_CRC;
    if (kind == FR_TOO_LONG) begin
      len_i = $urandom_range(1) ? mx + 1 : $urandom_range(65535, mx + 1);
    end else begin
      case ($urandom_range(9))
        0: len_i = 0;
        1: len_i = (mx <= 300) ? mx : $urandom_range(300, 100);
        2: len_i = $urandom_range(80, 13);
        default: len_i = $urandom_range(12, 1);
      endcase
      if (len_i > mx) len_i = mx;
    end
    len_v = LenW'(len_i);
    body.push_back(ByteW'($urandom_range(255)));
    body.push_back(ByteW'($urandom_range(255)));
    body.push_back(len_v[7:0]);
    body.push_back(len_v[15:8]);
    if (kind != FR_TOO_LONG) begin
      for (int i = 0; i < len_i; i++)
        body.push_back(($urandom_range(7) == 0) ? sb.start_val
                                                : ByteW'($urandom_range(255)));
    end
    flip = '0;
    if (kind == FR_BAD_CRC) flip = CrcW'($urandom_range(65535, 1));
    case (kind)
      FR_TOO_LONG: keep = 5;
      FR_CUT:      keep = $urandom_range(body.size() + 2, 1);
      default:     keep = 0;
    endcase
    send_built(body, flip, keep);
    // A cut frame leaves the parser mid-frame; random bytes carry it back to hunting.
    while (sb.phase != PH_HUNT) send_byte(ByteW'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_noise();
    logic [ByteW-1:0] b;
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++) begin
      b = ByteW'($urandom_range(255));
      if (b == sb.start_val) b = ~b;
      send_byte(b, 1'b0);
    end
  endtask

  task automatic run_segment(input int target);
    int goal;
    int pick;
    goal = items_sent + target;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 68) send_frame(FR_GOOD);
      else if (pick < 78) send_frame(FR_BAD_CRC);
      else if (pick < 86) send_frame(FR_TOO_LONG);
      else if (pick < 93) send_frame(FR_CUT);
      else send_noise();
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [AddrW-3:0] idx, input logic [DataW-1:0] value);
    logic [DataW-1:0] back;
    logic [DataW-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == RegStartByte) sb.start_val = value[ByteW-1:0];
    else sb.max_len = value[LenW-1:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    back = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    want = (idx == RegStartByte) ? {24'h0, sb.start_val} : {16'h0, sb.max_len};
    if (back !== want) sb.report_mismatch("register readback", back, want);
    @(posedge clk);
  endtask

  initial begin
    logic [ByteW-1:0] body[$];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hunting ignores bytes that are not the start byte.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Zero-length frame with a good CRC.
    body = '{8'hFF, 8'h00, 8'h00, 8'h00};
    send_built(body, 16'h0000, 0);
    // Start byte as sequence and payload data, CRC off by one bit.
    body = '{8'h00, StartByteReset, 8'h02, 8'h00, StartByteReset, 8'hFF};
    send_built(body, 16'h0001, 0);
    // Declared length one above the reset limit.
    body = '{8'h01, 8'h02, 8'h01, 8'h04};
    send_built(body, 16'h0000, 5);
    drain();

    run_segment(SegmentItems);
    drain();
    write_reg(RegStartByte, 32'd0);
    write_reg(RegMaxPayload, 32'd0);
    run_segment(SegmentItems);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 29;
    write_reg(RegStartByte, 32'd255);
    write_reg(RegMaxPayload, 32'd65535);
    run_segment(SegmentItems);
    drain();
    write_reg(RegStartByte, $urandom_range(254, 1));
    write_reg(RegMaxPayload, $urandom_range(300, 1));
    run_segment(SegmentItems);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(RegStartByte, $urandom_range(255));
    write_reg(RegMaxPayload, $urandom_range(2000, 301));
    // The receiver stalls for a long stretch while bytes keep coming.
    hold_requests++;
    run_segment(SegmentItems);
    drain();
    write_reg(RegStartByte, 32'h55);
    write_reg(RegMaxPayload, $urandom_range(65535));
    run_segment(SegmentItems);
    drain();
    repeat (10) @(posedge clk);

    $display("%0d result beats checked, %0d payload bytes passed through", sb.checked,
             sb.n_payload);
    $display("frames: %0d good, %0d CRC mismatch, %0d dropped for length", sb.n_good,
             sb.n_bad, sb.n_drop);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
